// ===== design/sssp_pkg.sv =====
// Shared types, constants and handshake structs for the shortest path block.
package sssp_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 1024;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int NV_W       = 7;
  localparam int DIST_OUT_W = 22;
  localparam logic [DIST_OUT_W-1:0] DIST_MAX = {DIST_OUT_W{1'b1}};
  localparam logic [NV_W-1:0] NV_RESET = 7'd64;

  typedef enum logic [1:0] {
    FUNC_DIRECTED   = 2'd0,
    FUNC_UNDIRECTED = 2'd1,
    FUNC_RUN        = 2'd2,
    FUNC_NONE       = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD2,
    ST_INIT,
    ST_SEL_START,
    ST_SEL,
    ST_SEL_END,
    ST_SEL_DONE,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_EDGE_REL,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    emit_status;
    status_t status_code;
    logic    store_fwd;
    logic    store_rev;
    logic    init_run;
    logic    scan_start;
    logic    scan_step;
    logic    scan_flush;
    logic    take_vertex;
    logic    edge_read;
    logic    head_read;
    logic    relax;
    logic    edge_adv;
    logic    out_read;
    logic    out_load;
    logic    out_adv;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  range_bad;
    logic  full;
    logic  found;
    logic  scan_last;
    logic  no_edges;
    logic  edge_hit;
    logic  edge_last;
    logic  out_busy;
    logic  out_last;
  } stat_t;

endpackage

// ===== design/single_source_shortest_path.sv =====
// Top level: Dijkstra shortest path engine with edge store and APB configuration.
// An edge load is answered with a status from the decode state; an undirected load also stores the reverse edge.
// A run repeats selection rounds: a scan over the vertices, then a read of every stored edge
// and a relaxation for each edge leaving the chosen vertex; then one result per vertex is emitted.
// One item is worked at a time; the vertex store with its single read port sets the round cost.
// Reset (synchronous, rst_n low) empties the edge store and sets num_vertices to 64.
module single_source_shortest_path
  import sssp_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // from_vertex[5:0], to_vertex[11:6], weight[27:12]
  input  logic [1:0]  in_tuser,   // func[1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // vertex[5:0], distance[27:6], reachable[28],
                                  // predecessor[34:29], has_predecessor[35], status[37:36]
  output logic        out_tlast,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [NV_W-1:0] nv_r;
  cmd_t            cmd;
  stat_t           st;

  // The only register, num_vertices, lives at byte address 0.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {25'd0, nv_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= NV_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == 1'b0) begin
      nv_r <= cfg_pwdata[NV_W-1:0];
    end
  end

  // The controller sequences decode, selection, relaxation and output; the
  // datapath holds both stores, the visit flags and the result register.
  sssp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  sssp_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .num_vertices (nv_r),
    .in_func      (in_tuser),
    .in_from      (in_tdata[5:0]),
    .in_to        (in_tdata[11:6]),
    .in_weight    (in_tdata[27:12]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_data     (out_tdata),
    .out_last     (out_tlast)
  );

endmodule

// ===== design/sssp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module sssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sssp_ctrl.sv =====
// Sequencer for edge loads, vertex selection, relaxation and result output.
module sssp_ctrl
  import sssp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !st.out_busy) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (st.func)
          FUNC_DIRECTED: state_nxt = ST_IDLE;
          FUNC_UNDIRECTED: begin
            state_nxt = (st.range_bad || st.full) ? ST_IDLE : ST_LOAD2;
          end
          FUNC_RUN: state_nxt = st.range_bad ? ST_IDLE : ST_INIT;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_LOAD2:     state_nxt = ST_IDLE;
      ST_INIT:      state_nxt = ST_SEL_START;
      ST_SEL_START: state_nxt = ST_SEL;
      ST_SEL: begin
        if (st.scan_last) state_nxt = ST_SEL_END;
      end
      ST_SEL_END:   state_nxt = ST_SEL_DONE;
      ST_SEL_DONE: begin
        if (!st.found) state_nxt = ST_OUT_RD;
        else if (st.no_edges) state_nxt = ST_SEL_START;
        else state_nxt = ST_EDGE_RD;
      end
      ST_EDGE_RD:   state_nxt = ST_EDGE_CHK;
      ST_EDGE_CHK: begin
        if (st.edge_hit) state_nxt = ST_EDGE_REL;
        else if (st.edge_last) state_nxt = ST_SEL_START;
        else state_nxt = ST_EDGE_RD;
      end
      ST_EDGE_REL: begin
        state_nxt = st.edge_last ? ST_SEL_START : ST_EDGE_RD;
      end
      ST_OUT_RD:    state_nxt = ST_OUT_LD;
      ST_OUT_LD:    state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (!st.out_busy) state_nxt = st.out_last ? ST_IDLE : ST_OUT_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = !st.out_busy;
        cmd.capture = in_valid && !st.out_busy;
      end
      ST_DECODE: begin
        if (st.func == FUNC_DIRECTED || st.func == FUNC_UNDIRECTED) begin
          cmd.emit_status = 1'b1;
          if (st.range_bad) cmd.status_code = STAT_RANGE;
          else if (st.full) cmd.status_code = STAT_FULL;
          else cmd.status_code = STAT_OK;
          cmd.store_fwd = !st.range_bad && !st.full;
        end else if (st.func == FUNC_RUN && st.range_bad) begin
          cmd.emit_status = 1'b1;
          cmd.status_code = STAT_RANGE;
        end
      end
      ST_LOAD2:     cmd.store_rev = 1'b1;
      ST_INIT:      cmd.init_run = 1'b1;
      ST_SEL_START: cmd.scan_start = 1'b1;
      ST_SEL:       cmd.scan_step = 1'b1;
      ST_SEL_END:   cmd.scan_flush = 1'b1;
      ST_SEL_DONE:  cmd.take_vertex = st.found;
      ST_EDGE_RD:   cmd.edge_read = 1'b1;
      ST_EDGE_CHK: begin
        cmd.head_read = st.edge_hit;
        cmd.edge_adv  = !st.edge_hit;
      end
      ST_EDGE_REL: begin
        cmd.relax    = 1'b1;
        cmd.edge_adv = 1'b1;
      end
      ST_OUT_RD:    cmd.out_read = 1'b1;
      ST_OUT_LD:    cmd.out_load = 1'b1;
      ST_OUT_WAIT:  cmd.out_adv = !st.out_busy && !st.out_last;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/sssp_dp.sv =====
// Datapath: edge store, vertex store, visit flags, selection and output register.
module sssp_dp
  import sssp_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cmd_t            cmd,
  output stat_t           st,
  input  logic [NV_W-1:0] num_vertices,
  input  logic [1:0]      in_func,
  input  logic [5:0]      in_from,
  input  logic [5:0]      in_to,
  input  logic [15:0]     in_weight,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [39:0]     out_data,
  output logic            out_last
);

  localparam int VB  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int EA  = $clog2(MAX_EDGES);
  localparam int EB  = $clog2(MAX_EDGES + 1);
  localparam int DW  = WEIGHT_BITS + VB;
  localparam int EW  = 2 * VB + WEIGHT_BITS;
  localparam int VW  = DW + VB;

  // Captured item.
  func_t                  func_r;
  logic [5:0]             a_r, b_r;
  logic [15:0]            w_r;

  logic [EB-1:0]          ec_r, ec_nxt;
  logic [EA-1:0]          e_r, e_nxt;
  logic [VB-1:0]          scan_r, scan_nxt;
  logic [VB-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic                   cmp_v_r, cmp_v_nxt;
  logic                   found_r, found_nxt;
  logic [VB-1:0]          u_r, u_nxt;
  logic [DW-1:0]          du_r, du_nxt;
  logic [VB-1:0]          oi_r, oi_nxt;
  logic [MAX_VERTICES-1:0] reach_r, reach_nxt;
  logic [MAX_VERTICES-1:0] done_r, done_nxt;
  logic [MAX_VERTICES-1:0] pv_r, pv_nxt;
  logic                   ov_r, ov_nxt;
  logic [39:0]            od_r, od_nxt;
  logic                   ol_r, ol_nxt;

  logic [NW-1:0]          n;
  logic [VB-1:0]          n_m1;

  // Edge store.
  logic                   e_we, e_re;
  logic [EA-1:0]          e_waddr;
  logic [EW-1:0]          e_wdata, e_rdata;
  logic [VB-1:0]          e_tail, e_head;
  logic [WEIGHT_BITS-1:0] e_cost;

  // Vertex store: distance in the low bits, predecessor above.
  logic                   v_we, v_re;
  logic [VB-1:0]          v_waddr, v_raddr;
  logic [VW-1:0]          v_wdata, v_rdata;
  logic [DW-1:0]          v_dist;
  logic [VB-1:0]          v_pred;

  logic [DW:0]            cand;
  logic                   better;
  logic                   take;
  logic [63:0]            dwide;
  logic [DIST_OUT_W-1:0]  dsat;

  always_comb begin
    if (num_vertices == '0) n = NW'(1);
    else if (32'(num_vertices) > 32'(MAX_VERTICES)) n = NW'(MAX_VERTICES);
    else n = NW'(num_vertices);
    n_m1 = VB'(32'(n) - 32'd1);
  end

  assign e_tail = e_rdata[VB-1:0];
  assign e_head = e_rdata[2*VB-1:VB];
  assign e_cost = e_rdata[EW-1:2*VB];
  assign v_dist = v_rdata[DW-1:0];
  assign v_pred = v_rdata[VW-1:DW];

  assign cand   = {1'b0, du_r} + (DW+1)'(e_cost);
  assign better = !reach_r[e_head] || (cand < {1'b0, v_dist});
  assign take   = cmp_v_r && reach_r[cmp_idx_r] && !done_r[cmp_idx_r] &&
                  (!found_r || v_dist < du_r);
  assign dwide  = 64'(v_dist);
  assign dsat   = (dwide > 64'(DIST_MAX)) ? DIST_MAX : dwide[DIST_OUT_W-1:0];

  always_comb begin
    st.func      = func_r;
    st.range_bad = (32'(a_r) >= 32'(n)) ||
                   (func_r != FUNC_RUN && 32'(b_r) >= 32'(n));
    st.full      = (32'(MAX_EDGES) - 32'(ec_r)) <
                   ((func_r == FUNC_UNDIRECTED) ? 32'd2 : 32'd1);
    st.found     = found_r;
    st.scan_last = scan_r == n_m1;
    st.no_edges  = ec_r == '0;
    st.edge_hit  = (e_tail == u_r) && (32'(e_head) < 32'(n));
    st.edge_last = (EB'(e_r) + EB'(1)) == ec_r;
    st.out_busy  = ov_r;
    st.out_last  = oi_r == n_m1;
  end

  // Memory port steering.
  always_comb begin
    e_we    = cmd.store_fwd || cmd.store_rev;
    e_waddr = ec_r[EA-1:0];
    e_wdata = cmd.store_rev ? {WEIGHT_BITS'(w_r), VB'(a_r), VB'(b_r)}
                            : {WEIGHT_BITS'(w_r), VB'(b_r), VB'(a_r)};
    e_re    = cmd.edge_read;

    v_we    = cmd.init_run || (cmd.relax && better);
    v_waddr = cmd.init_run ? VB'(a_r) : e_head;
    v_wdata = cmd.init_run ? '0 : {u_r, cand[DW-1:0]};
    v_re    = cmd.scan_step || cmd.head_read || cmd.out_read;
    if (cmd.head_read) v_raddr = e_head;
    else if (cmd.out_read) v_raddr = oi_r;
    else v_raddr = scan_r;
  end

  always_comb begin
    ec_nxt      = ec_r;
    e_nxt       = e_r;
    scan_nxt    = scan_r;
    cmp_idx_nxt = cmp_idx_r;
    cmp_v_nxt   = cmp_v_r;
    found_nxt   = found_r;
    u_nxt       = u_r;
    du_nxt      = du_r;
    oi_nxt      = oi_r;
    reach_nxt   = reach_r;
    done_nxt    = done_r;
    pv_nxt      = pv_r;
    ov_nxt      = ov_r;
    od_nxt      = od_r;
    ol_nxt      = ol_r;

    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (e_we) ec_nxt = ec_r + EB'(1);

    if (cmd.init_run) begin
      reach_nxt          = '0;
      done_nxt           = '0;
      pv_nxt             = '0;
      reach_nxt[VB'(a_r)] = 1'b1;
      oi_nxt             = '0;
    end
    if (cmd.scan_start) begin
      scan_nxt  = '0;
      cmp_v_nxt = 1'b0;
      found_nxt = 1'b0;
    end
    if (cmd.scan_step || cmd.scan_flush) begin
      if (take) begin
        u_nxt     = cmp_idx_r;
        du_nxt    = v_dist;
        found_nxt = 1'b1;
      end
      cmp_v_nxt   = cmd.scan_step;
      cmp_idx_nxt = scan_r;
      if (cmd.scan_step) scan_nxt = scan_r + VB'(1);
    end
    if (cmd.take_vertex) begin
      done_nxt[u_r] = 1'b1;
      e_nxt         = '0;
    end
    if (cmd.relax && better) begin
      reach_nxt[e_head] = 1'b1;
      pv_nxt[e_head]    = 1'b1;
    end
    if (cmd.edge_adv) e_nxt = e_r + EA'(1);
    if (cmd.out_adv) oi_nxt = oi_r + VB'(1);

    if (cmd.emit_status) begin
      ov_nxt = 1'b1;
      od_nxt = {2'b00, cmd.status_code, 36'd0};
      ol_nxt = 1'b1;
    end
    if (cmd.out_load) begin
      ov_nxt = 1'b1;
      od_nxt = {2'b00, STAT_OK, pv_r[oi_r],
                pv_r[oi_r] ? 6'(v_pred) : 6'd0,
                reach_r[oi_r],
                reach_r[oi_r] ? dsat : {DIST_OUT_W{1'b0}},
                6'(oi_r)};
      ol_nxt = oi_r == n_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_r    <= '0;
      reach_r <= '0;
      done_r  <= '0;
      pv_r    <= '0;
      ov_r    <= 1'b0;
      cmp_v_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      ec_r    <= ec_nxt;
      reach_r <= reach_nxt;
      done_r  <= done_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
      cmp_v_r <= cmp_v_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func_t'(in_func);
      a_r    <= in_from;
      b_r    <= in_to;
      w_r    <= in_weight;
    end
    e_r       <= e_nxt;
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    u_r       <= u_nxt;
    du_r      <= du_nxt;
    oi_r      <= oi_nxt;
    od_r      <= od_nxt;
    ol_r      <= ol_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign out_last  = ol_r;

  sssp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_r),
    .rdata (e_rdata)
  );

  sssp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vert_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .re    (v_re),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

endmodule
